@@ hw/rtl/assert_macros.svh @@
// Assertion helpers included by the tracker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, skipped while in reset
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ hw/rtl/swmm_pkg.sv @@
`default_nettype none
package swmm_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int FIELD_BITS   = 32;

    // Commands
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] drive_value;
        logic signed [31:0] measured_value;
        logic signed [31:0] setpoint_value;
        logic signed [31:0] error_value;
        logic               terms_valid;
        logic signed [31:0] p_term;
        logic signed [31:0] i_term;
        logic signed [31:0] d_term;
        logic [31:0]        time_stamp;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         channel;
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic [8:0]         point_count;
        logic [31:0]        newest_time;
        logic [31:0]        oldest_time;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    // Lane control from the sequencer
    typedef struct packed {
        logic start;   // reset extremes before a scan
        logic sample;  // a stored sample is on the read bus
        logic terms;   // that sample carries P, I and D terms
    } lane_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/swmm_lane.sv @@
`default_nettype none
// One channel's running max and min over a scan of the window
module swmm_lane #(
    parameter int VALUE_BITS = 32,
    parameter bit TERM_LANE  = 1'b0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire swmm_pkg::lane_ctl_t          ctl,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic signed [VALUE_BITS-1:0]      max_value,
    output logic signed [VALUE_BITS-1:0]      min_value,
    output logic                              any
);
    logic signed [VALUE_BITS-1:0] hi_reg, lo_reg;
    logic any_reg;
    logic take;

    assign take = ctl.sample && (!TERM_LANE || ctl.terms);

    // Clear flag at scan start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            any_reg <= 1'b0;
        else if (ctl.start)
            any_reg <= 1'b0;
        else if (take)
            any_reg <= 1'b1;
    end

    // Fold in the sample
    always_ff @(posedge clk)
    begin
        if (take && (!any_reg || value > hi_reg))
            hi_reg <= value;
        if (take && (!any_reg || value < lo_reg))
            lo_reg <= value;
    end

    assign max_value = hi_reg;
    assign min_value = lo_reg;
    assign any       = any_reg;
endmodule
`default_nettype wire

@@ hw/rtl/swmm_merge.sv @@
`default_nettype none
// Pick one lane's result per output slot and hold it behind the output register
module swmm_merge #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      load,
    input  wire logic [2:0]                                channel,
    input  wire logic [swmm_pkg::NUM_CHANNELS*VALUE_BITS-1:0] hi_bus,
    input  wire logic [swmm_pkg::NUM_CHANNELS*VALUE_BITS-1:0] lo_bus,
    input  wire logic [swmm_pkg::NUM_CHANNELS-1:0]         any_bus,
    input  wire logic [8:0]                                point_count,
    input  wire logic [31:0]                               newest_time,
    input  wire logic [31:0]                               oldest_time,
    input  wire logic [1:0]                                status,
    output logic                                           valid,
    input  wire logic                                      stall,
    output swmm_pkg::out_item_t                            item
);
    logic valid_reg;
    swmm_pkg::out_item_t item_reg, item_next;
    logic [VALUE_BITS-1:0] hi_sel, lo_sel;
    logic any_sel;

    // Select lane
    always_comb
    begin
        hi_sel  = '0;
        lo_sel  = '0;
        any_sel = 1'b0;
        for (int i = 0; i < swmm_pkg::NUM_CHANNELS; i++)
        begin
            if (channel == 3'(i))
            begin
                hi_sel  = hi_bus[i*VALUE_BITS +: VALUE_BITS];
                lo_sel  = lo_bus[i*VALUE_BITS +: VALUE_BITS];
                any_sel = any_bus[i];
            end
        end
        item_next.channel     = channel;
        item_next.max_value   = any_sel ? 32'(signed'(hi_sel)) : '0;
        item_next.min_value   = any_sel ? 32'(signed'(lo_sel)) : '0;
        item_next.point_count = point_count;
        item_next.newest_time = newest_time;
        item_next.oldest_time = oldest_time;
        item_next.status      = status;
        item_next.last        = (channel == 3'(swmm_pkg::NUM_CHANNELS - 1));
    end

    // Hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;
endmodule
`default_nettype wire

@@ hw/rtl/sliding_window_min_max_tracker.sv @@
// Sliding-window min/max tracker. Each accepted item (append, remove oldest,
// clear) updates a circular window of up to WINDOW_DEPTH samples and then
// yields seven result items, one per channel in channel order, the seventh
// marked last. After the update the block scans the window one stored sample
// a cycle from a sample memory, with seven lanes folding max and min in
// parallel; in_stall holds off the next item until the seventh result is
// loaded into the output register. Memories need no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module sliding_window_min_max_tracker #(
    parameter int WINDOW_DEPTH = 256,
    parameter int VALUE_BITS   = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire swmm_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output swmm_pkg::out_item_t      out_item
);
    localparam int NC = swmm_pkg::NUM_CHANNELS;
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = NC * VALUE_BITS + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TIME = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [1:0] status_reg, status_next;
    logic [2:0] chan_reg, chan_next;
    logic [1:0] tstep_reg, tstep_next;
    logic [31:0] newest_reg, oldest_reg;
    logic tfirst_reg;

    logic [SW-1:0] sample_mem [WINDOW_DEPTH];
    logic [31:0]   time_mem [WINDOW_DEPTH];
    logic [SW-1:0] rd_sample;
    logic [31:0]   rd_time;
    logic          rd_valid_reg;
    logic          accept, load;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr, t_addr;
    logic [SW-1:0] wr_data;
    logic          rd_en, start;

    swmm_pkg::lane_ctl_t lane_ctl;
    logic [NC*VALUE_BITS-1:0] hi_bus, lo_bus;
    logic [NC-1:0] any_bus;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(WINDOW_DEPTH))
            s = s - (CW+1)'(WINDOW_DEPTH);
        return AW'(s);
    endfunction

    function automatic logic [VALUE_BITS-1:0] to_val(input logic [31:0] f);
        return VALUE_BITS'(signed'(f));
    endfunction

    // Build write word
    always_comb
    begin
        wr_data = {in_item.terms_valid,
                   in_item.terms_valid ? to_val(in_item.d_term) : '0,
                   in_item.terms_valid ? to_val(in_item.i_term) : '0,
                   in_item.terms_valid ? to_val(in_item.p_term) : '0,
                   to_val(in_item.error_value), to_val(in_item.setpoint_value),
                   to_val(in_item.measured_value), to_val(in_item.drive_value)};
        wr_addr = wrap_add(head_reg, count_reg);
        wr_en   = accept && in_item.cmd == swmm_pkg::CMD_APPEND
                  && count_reg < CW'(WINDOW_DEPTH);
    end

    // Control sequencer
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        status_next = status_reg;
        chan_next   = chan_reg;
        tstep_next  = tstep_reg;
        rd_en       = 1'b0;
        rd_addr     = wrap_add(head_reg, scan_reg);
        t_addr      = head_reg;
        start       = 1'b0;
        load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = swmm_pkg::ST_OK;
                    case (in_item.cmd)
                        swmm_pkg::CMD_APPEND:
                        begin
                            if (count_reg >= CW'(WINDOW_DEPTH))
                                status_next = swmm_pkg::ST_FULL;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        swmm_pkg::CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                                status_next = swmm_pkg::ST_EMPTY;
                            else
                            begin
                                head_next  = wrap_add(head_reg, CW'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end
                        swmm_pkg::CMD_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default: ;
                    endcase
                    start      = 1'b1;
                    scan_next  = '0;
                    tstep_next = '0;
                    chan_next  = '0;
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                // Fetch oldest then newest time stamp
                tstep_next = tstep_reg + 1'b1;
                if (tstep_reg == 2'd0)
                    t_addr = head_reg;
                else
                    t_addr = wrap_add(head_reg, count_reg - CW'(count_reg != '0));
                if (tstep_reg == 2'd2)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Read one sample a cycle
                if (scan_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                else
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (!out_valid || !out_stall)
                begin
                    load = 1'b1;
                    if (chan_reg == 3'(NC - 1))
                        state_next = S_IDLE;
                    else
                        chan_next = chan_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            status_reg   <= swmm_pkg::ST_OK;
            chan_reg     <= '0;
            tstep_reg    <= '0;
            rd_valid_reg <= 1'b0;
            tfirst_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            status_reg   <= status_next;
            chan_reg     <= chan_next;
            tstep_reg    <= tstep_next;
            rd_valid_reg <= rd_en;
            tfirst_reg   <= (state_reg == S_TIME && tstep_reg == 2'd0);
        end
    end

    // Sample and time memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
            sample_mem[wr_addr] <= wr_data;
        rd_sample <= sample_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            time_mem[wr_addr] <= in_item.time_stamp;
        rd_time <= time_mem[t_addr];
    end

    // Latch time stamps
    always_ff @(posedge clk)
    begin
        if (tfirst_reg)
            oldest_reg <= (count_reg != '0) ? rd_time : '0;
        if (state_reg == S_TIME && tstep_reg == 2'd2)
            newest_reg <= (count_reg != '0) ? rd_time : '0;
    end

    assign lane_ctl.start  = start;
    assign lane_ctl.sample = rd_valid_reg;
    assign lane_ctl.terms  = rd_sample[SW-1];

    // Lanes
    for (genvar g = 0; g < NC; g++)
    begin : g_lane
        swmm_lane #(
            .VALUE_BITS(VALUE_BITS),
            .TERM_LANE (g >= 4)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lane_ctl),
            .value    (rd_sample[g*VALUE_BITS +: VALUE_BITS]),
            .max_value(hi_bus[g*VALUE_BITS +: VALUE_BITS]),
            .min_value(lo_bus[g*VALUE_BITS +: VALUE_BITS]),
            .any      (any_bus[g])
        );
    end

    swmm_merge #(
        .VALUE_BITS(VALUE_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .channel    (chan_reg),
        .hi_bus     (hi_bus),
        .lo_bus     (lo_bus),
        .any_bus    (any_bus),
        .point_count(9'(count_reg)),
        .newest_time(newest_reg),
        .oldest_time(oldest_reg),
        .status     (status_reg),
        .valid      (out_valid),
        .stall      (out_stall),
        .item       (out_item)
    );

    `CHK_IMPL(a_count_range, 1'b1, count_reg <= CW'(WINDOW_DEPTH))
    `CHK_IMPL(a_no_accept_busy, state_reg != S_IDLE, !accept)
    `CHK_IMPL(a_scan_bound, state_reg == S_SCAN, scan_reg <= count_reg)
    `CHK_NEXT(a_accept_to_time, accept, state_reg == S_TIME)
endmodule
`default_nettype wire

@@ bench/sliding_window_min_max_tracker_tb.sv @@
`default_nettype none
module sliding_window_min_max_tracker_tb;

    localparam int DEPTH = 256;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    swmm_pkg::in_item_t    in_item;
    logic                  out_valid;
    logic                  out_stall;
    swmm_pkg::out_item_t   out_item;

    // window copy held by the predictor
    logic signed [31:0] win_val [DEPTH][swmm_pkg::NUM_CHANNELS];
    logic               win_terms [DEPTH];
    logic [31:0]        win_time [DEPTH];
    int unsigned        win_head;
    int unsigned        win_count;

    swmm_pkg::out_item_t pending_results[$];
    int          fail_count;
    int          idle_cycles;
    bit          send_gaps;
    bit          recv_gaps;
    bit          recv_hold;

    sliding_window_min_max_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the window copy and queue its seven results
    task automatic predict_window(input swmm_pkg::in_item_t it);
        logic [1:0]          st;
        logic [31:0]         newest;
        logic [31:0]         oldest;
        logic signed [31:0]  hi;
        logic signed [31:0]  lo;
        logic signed [31:0]  v;
        bit                  any;
        int unsigned         slot;
        swmm_pkg::out_item_t r;
        st = swmm_pkg::ST_OK;
        if (it.cmd == swmm_pkg::CMD_APPEND)
        begin
            if (win_count >= DEPTH)
                st = swmm_pkg::ST_FULL;
            else
            begin
                slot = (win_head + win_count) % DEPTH;
                win_val[slot][0] = it.drive_value;
                win_val[slot][1] = it.measured_value;
                win_val[slot][2] = it.setpoint_value;
                win_val[slot][3] = it.error_value;
                win_val[slot][4] = it.terms_valid ? it.p_term : 32'sd0;
                win_val[slot][5] = it.terms_valid ? it.i_term : 32'sd0;
                win_val[slot][6] = it.terms_valid ? it.d_term : 32'sd0;
                win_terms[slot] = it.terms_valid;
                win_time[slot] = it.time_stamp;
                win_count++;
            end
        end
        else if (it.cmd == swmm_pkg::CMD_REMOVE)
        begin
            if (win_count == 0)
                st = swmm_pkg::ST_EMPTY;
            else
            begin
                win_head = (win_head + 1) % DEPTH;
                win_count--;
            end
        end
        else if (it.cmd == swmm_pkg::CMD_CLEAR)
        begin
            win_head = 0;
            win_count = 0;
        end
        newest = '0;
        oldest = '0;
        if (win_count > 0)
        begin
            oldest = win_time[win_head];
            newest = win_time[(win_head + win_count - 1) % DEPTH];
        end
        for (int ch = 0; ch < swmm_pkg::NUM_CHANNELS; ch++)
        begin
            any = 1'b0;
            hi = '0;
            lo = '0;
            for (int k = 0; k < win_count; k++)
            begin
                slot = (win_head + k) % DEPTH;
                if (ch >= 4 && !win_terms[slot])
                    continue;
                v = win_val[slot][ch];
                if (!any)
                begin
                    hi = v;
                    lo = v;
                    any = 1'b1;
                end
                else
                begin
                    if (v > hi) hi = v;
                    if (v < lo) lo = v;
                end
            end
            r.channel     = ch[2:0];
            r.max_value   = hi;
            r.min_value   = lo;
            r.point_count = win_count[8:0];
            r.newest_time = newest;
            r.oldest_time = oldest;
            r.status      = st;
            r.last        = (ch == swmm_pkg::NUM_CHANNELS - 1);
            pending_results.push_back(r);
        end
    endtask

    // Offer one item, hold it until accepted
    task automatic send_item(input swmm_pkg::in_item_t it);
        while (send_gaps && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_window(it);
    endtask

    function automatic swmm_pkg::in_item_t random_sample(input logic [1:0] cmd);
        swmm_pkg::in_item_t it;
        it.cmd            = cmd;
        it.drive_value    = $urandom;
        it.measured_value = $urandom;
        it.setpoint_value = $urandom;
        it.error_value    = $urandom;
        it.terms_valid    = 1'($urandom_range(1));
        it.p_term         = $urandom;
        it.i_term         = $urandom;
        it.d_term         = $urandom;
        it.time_stamp     = $urandom;
        // narrow values now and then so that ties and near values occur
        if ($urandom_range(3) == 0)
        begin
            it.drive_value = $signed($urandom_range(7)) - 32'sd3;
            it.p_term      = $signed($urandom_range(7)) - 32'sd3;
        end
        return it;
    endfunction

    function automatic swmm_pkg::in_item_t extreme_sample(input logic signed [31:0] v,
                                                          input logic tv,
                                                          input logic [31:0] ts);
        swmm_pkg::in_item_t it;
        it.cmd = swmm_pkg::CMD_APPEND;
        it.drive_value = v;
        it.measured_value = ~v;
        it.setpoint_value = v;
        it.error_value = ~v;
        it.terms_valid = tv;
        it.p_term = v;
        it.i_term = ~v;
        it.d_term = v;
        it.time_stamp = ts;
        return it;
    endfunction

    // Drop valid, then wait until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Extremes, every command, empty removes, absent terms, unknown command
    task automatic test_directed();
        swmm_pkg::in_item_t it;
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(extreme_sample(32'sh7fffffff, 1'b0, 32'hffffffff));
        send_item(extreme_sample(32'sh80000000, 1'b1, 32'h00000000));
        send_item(extreme_sample(32'sd0, 1'b1, 32'h00010000));
        send_item(extreme_sample(-32'sd1, 1'b0, 32'h80000000));
        it = random_sample(swmm_pkg::CMD_APPEND);
        it.cmd = CMD_UNUSED;
        send_item(it);
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(extreme_sample(32'sh7fffffff, 1'b1, 32'h7fffffff));
        send_item(random_sample(swmm_pkg::CMD_CLEAR));
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(random_sample(swmm_pkg::CMD_CLEAR));
        drain_results();
    endtask

    // Fill the window to the top, then reject appends while full
    task automatic test_full_window();
        recv_hold = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            send_item(random_sample(swmm_pkg::CMD_APPEND));
        send_item(random_sample(swmm_pkg::CMD_APPEND));
        send_item(random_sample(swmm_pkg::CMD_APPEND));
        send_item(random_sample(swmm_pkg::CMD_REMOVE));
        send_item(random_sample(swmm_pkg::CMD_APPEND));
        send_item(random_sample(swmm_pkg::CMD_APPEND));
        send_item(random_sample(swmm_pkg::CMD_CLEAR));
        drain_results();
    endtask

    // Mostly appends and removes with a small window, some clears and noise
    task automatic test_random();
        int unsigned sel;
        for (int i = 0; i < 70; i++)
        begin
            if (i == 20) send_gaps = 1'b0;
            if (i == 20) recv_gaps = 1'b0;
            if (i == 55) send_gaps = 1'b1;
            if (i == 55) recv_gaps = 1'b1;
            sel = $urandom_range(99);
            if (sel < 55)
                send_item(random_sample(swmm_pkg::CMD_APPEND));
            else if (sel < 92)
                send_item(random_sample(swmm_pkg::CMD_REMOVE));
            else if (sel < 97)
                send_item(random_sample(swmm_pkg::CMD_CLEAR));
            else
                send_item(random_sample(CMD_UNUSED));
        end
        drain_results();
    endtask

    // Receiver: random stalls, plus one long hold-off while items pile up
    initial
    begin
        out_stall <= 1'b1;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_hold)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                recv_hold = 1'b0;
            end
            out_stall <= recv_gaps && ($urandom_range(99) < 20);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        swmm_pkg::out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result channel %0d", out_item.channel);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_item.channel !== exp_r.channel)
                begin
                    $error("channel exp %0d got %0d", exp_r.channel, out_item.channel);
                    fail_count++;
                end
                if (out_item.max_value !== exp_r.max_value)
                begin
                    $error("max_value exp %0d got %0d", exp_r.max_value, out_item.max_value);
                    fail_count++;
                end
                if (out_item.min_value !== exp_r.min_value)
                begin
                    $error("min_value exp %0d got %0d", exp_r.min_value, out_item.min_value);
                    fail_count++;
                end
                if (out_item.point_count !== exp_r.point_count)
                begin
                    $error("point_count exp %0d got %0d", exp_r.point_count,
                           out_item.point_count);
                    fail_count++;
                end
                if (out_item.newest_time !== exp_r.newest_time)
                begin
                    $error("newest_time exp %h got %h", exp_r.newest_time,
                           out_item.newest_time);
                    fail_count++;
                end
                if (out_item.oldest_time !== exp_r.oldest_time)
                begin
                    $error("oldest_time exp %h got %h", exp_r.oldest_time,
                           out_item.oldest_time);
                    fail_count++;
                end
                if (out_item.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, out_item.status);
                    fail_count++;
                end
                if (out_item.last !== exp_r.last)
                begin
                    $error("last exp %0d got %0d", exp_r.last, out_item.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        fail_count  = 0;
        idle_cycles = 0;
        win_head    = 0;
        win_count   = 0;
        send_gaps   = 1'b1;
        recv_gaps   = 1'b1;
        recv_hold   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_window();
        test_random();
        if (pending_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_lane.sv
hw/rtl/swmm_merge.sv
hw/rtl/sliding_window_min_max_tracker.sv
bench/sliding_window_min_max_tracker_tb.sv
